[rtl/smma_pkg.sv]
// Shared types and constants for the square matrix multiply-accumulate block.
// Command codes, sequencer states, result kinds and the Q8.8 clamp.
// No dependencies.
package smma_pkg;

  typedef enum logic [2:0] {
    CMD_WR_A    = 3'd0,
    CMD_WR_B    = 3'd1,
    CMD_WR_C    = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_RD_C    = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CRD   = 5'b00010,
    S_MAC   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic REG_MATRIX_SIZE = 1'b0;
  localparam logic [4:0] MATRIX_SIZE_RESET = 5'd16;

  localparam logic [47:0] C_MAXV = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] C_MINV = 48'h8000_0000_0000;

  // Clamp a Q32.16-wide value into the signed 16-bit Q8.8 range.
  function automatic logic [15:0] sat_q88(input logic signed [47:0] v);
    logic [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -48'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/square_matrix_multiply_accumulate.sv]
// Square matrix multiply-accumulate, C = C + A*B, with A, B and C in internal stores.
// Single-module design: command decode, one-MAC sequencer, stores, APB register.
// Depends on smma_pkg.

// Usage: each input word carries one command. A write goes to A, B or C.
// A and B values are clamped to Q8.8, C is stored as Q32.16. A read of C gives its
// result word through the registered store read and blocks the input while it is
// pending. A compute runs one shared 16x16 multiplier and one 48-bit saturating
// adder over every k of every (i,j), with n = min(matrix_size, N_MAX): each element
// loads C, issues n products and drains them through the store read, product and
// accumulate registers, and the input stays stalled until its finish word (kind 1)
// is in the output register. Indices at or beyond N_MAX are ignored on write and
// read back as zero. The overflow bit is cleared when a compute starts and set by
// any saturating addition.
module square_matrix_multiply_accumulate #(
  parameter int N_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  row_i,
  input  logic [3:0]  col_i,
  input  logic signed [47:0] value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic signed [47:0] result_value_o,
  output logic        overflow_o
);
  import smma_pkg::*;

  localparam int DEPTH = N_MAX * N_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(N_MAX);
  localparam int NW    = $clog2(N_MAX + 1);

  logic [15:0] a_mem [DEPTH];
  logic [15:0] b_mem [DEPTH];
  logic [47:0] c_mem [DEPTH];

  state_e      state_q, state_d;
  logic [4:0]  matrix_size_q;
  logic [NW-1:0] n_q, n_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic        v1_q, v2_q;
  logic [15:0] a_rd_q, b_rd_q;
  logic [47:0] c_rd_q;
  logic signed [31:0] prod_q;
  logic [47:0] acc_q;
  logic        flag_q;
  logic        rd_pend_q, rd_pend_d, rd_ok_q, rd_ok_d;
  logic        out_valid_q, out_kind_q, out_ovf_q;
  logic [47:0] out_value_q;

  logic        in_acc, in_ok, out_free, cfg_wr;
  logic [AW-1:0] in_idx, ij_idx;
  logic [AW-1:0] a_raddr, b_raddr, c_raddr, c_waddr;
  logic [47:0] c_wdata;
  logic        a_we, b_we, c_we;
  logic        issue, acc_load, flag_clr, out_load, out_kind_d;
  logic [47:0] out_value_d;
  logic        last_i, last_j, last_k;
  logic signed [48:0] acc_sum;
  logic        acc_ovf;
  logic [47:0] acc_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {27'd0, matrix_size_q} : 32'd0;

  assign in_stall_o = (state_q != S_IDLE) || rd_pend_q || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_ok      = (32'(row_i) < N_MAX) && (32'(col_i) < N_MAX);
  assign in_idx     = AW'(32'(row_i) * N_MAX + 32'(col_i));
  assign ij_idx     = AW'(32'(i_q) * N_MAX + 32'(j_q));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign last_i = (NW'(i_q) + NW'(1)) == n_q;
  assign last_j = (NW'(j_q) + NW'(1)) == n_q;
  assign last_k = (NW'(k_q) + NW'(1)) == n_q;

  // Saturating accumulate of one Q16.16 product into the Q32.16 sum.
  assign acc_sum  = $signed({acc_q[47], acc_q}) + $signed({{17{prod_q[31]}}, prod_q});
  assign acc_ovf  = acc_sum[48] ^ acc_sum[47];
  assign acc_next = acc_ovf ? (acc_sum[48] ? C_MINV : C_MAXV) : acc_sum[47:0];

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    rd_pend_d   = 1'b0;
    rd_ok_d     = rd_ok_q;
    a_we        = 1'b0;
    b_we        = 1'b0;
    c_we        = 1'b0;
    c_waddr     = in_idx;
    c_wdata     = value_i;
    c_raddr     = in_idx;
    a_raddr     = AW'(32'(i_q) * N_MAX + 32'(k_q));
    b_raddr     = AW'(32'(k_q) * N_MAX + 32'(j_q));
    issue       = 1'b0;
    acc_load    = 1'b0;
    flag_clr    = 1'b0;
    out_load    = 1'b0;
    out_kind_d  = KIND_READ;
    out_value_d = rd_ok_q ? c_rd_q : 48'd0;

    case (state_q)
      S_IDLE: begin
        if (rd_pend_q) begin
          out_load = 1'b1;
        end
        if (in_acc) begin
          case (cmd_i)
            CMD_WR_A: a_we = in_ok;
            CMD_WR_B: b_we = in_ok;
            CMD_WR_C: c_we = in_ok;
            CMD_COMPUTE: begin
              flag_clr = 1'b1;
              n_d = (32'(matrix_size_q) > N_MAX) ? NW'(N_MAX) : NW'(matrix_size_q);
              i_d = '0;
              j_d = '0;
              k_d = '0;
              state_d = (n_d == '0) ? S_DONE : S_CRD;
            end
            CMD_RD_C: begin
              rd_pend_d = 1'b1;
              rd_ok_d   = in_ok;
            end
            default: ;
          endcase
        end
      end
      S_CRD: begin
        c_raddr = ij_idx;
        k_d     = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        issue = 1'b1;
        // C element arrives from the store on the first issue cycle
        acc_load = (k_q == '0);
        if (last_k) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          c_we    = 1'b1;
          c_waddr = ij_idx;
          c_wdata = acc_q;
          state_d = S_CRD;
          if (last_j) begin
            j_d = '0;
            if (last_i) begin
              state_d = S_DONE;
            end else begin
              i_d = i_q + IW'(1);
            end
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_DONE;
          out_value_d = 48'd0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Stores: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[in_idx] <= sat_q88(value_i);
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[in_idx] <= sat_q88(value_i);
    end
    b_rd_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_rd_q <= c_mem[c_raddr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_rd_q) * $signed(b_rd_q);
    if (acc_load) begin
      acc_q <= c_rd_q;
    end else if (v2_q) begin
      acc_q <= acc_next;
    end
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_value_q <= out_value_d;
    end
    n_q <= n_d;
    i_q <= i_d;
    j_q <= j_d;
    k_q <= k_d;
    rd_ok_q <= rd_ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      matrix_size_q <= MATRIX_SIZE_RESET;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      flag_q        <= 1'b0;
      rd_pend_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      v1_q      <= issue;
      v2_q      <= v1_q;
      rd_pend_q <= rd_pend_d;
      if (cfg_wr && (paddr[2] == REG_MATRIX_SIZE)) begin
        matrix_size_q <= pwdata[4:0];
      end
      if (flag_clr) begin
        flag_q <= 1'b0;
      end else if (v2_q && acc_ovf) begin
        flag_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_ovf_q   <= flag_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign result_value_o = out_value_q;
  assign overflow_o     = out_ovf_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input not stalled during compute");

  a_read_finds_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("read word found output register occupied");

  a_element_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRD) |-> (!v1_q && !v2_q))
    else $error("MAC pipeline not drained at element start");

  a_done_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && out_kind_q == KIND_DONE))
    else $error("compute finish word not loaded");
`endif

endmodule
